[sv/sasum_pkg.sv]
// Shared types and constants for the subarray maximum sum block.
`default_nettype none

package sasum_pkg;

  // Default configuration
  localparam int unsigned MAX_LEN_DEF     = 1024;
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  // Result width; the total wraps modulo 2**TOTAL_W
  localparam int unsigned TOTAL_W = 36;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_WAIT,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } sasum_state_e;

endpackage

`default_nettype wire

[sv/sasum_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sasum_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/subarray_maximum_sum_top.sv]
// Top level of the streaming sum-of-subarray-maxima block.
`default_nettype none

// Takes one signed value per request on the input channel, with last marking the
// end of a sequence, and returns one result per sequence: the sum over every
// non-empty contiguous subarray of that subarray's maximum, as a 36-bit two's
// complement total (wrapping modulo 2**36), plus an overflow flag. A monotonic
// stack (strictly decreasing values) lives in a single RAM of MAX_LEN entries, each
// holding index, value and the sum of maxima of subarrays ending at that index; the
// top entry is mirrored in flops. Each element steps through accept, compare,
// multiply and add/push; every entry it pops costs a compare and then one RAM read
// to refill the top copy, or only the compare for a pop that empties the stack.
// The single multiplier and the one RAM read port force these steps in turn. Every
// element that is kept is pushed once and popped at most once. A last element adds
// a final step that moves the total into the output register; the output register
// lets the next sequence start while the result still waits to be taken, and the
// block only holds in that final step if a second result is ready before the first
// is taken. Elements beyond MAX_LEN are dropped on acceptance and set the overflow
// flag.
// Reset needs no clearing pass: only entries below the stack depth are ever read.
module subarray_maximum_sum_top
  #(
  parameter int unsigned MAX_LEN     = sasum_pkg::MAX_LEN_DEF,
  parameter int unsigned VALUE_WIDTH = sasum_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [VALUE_WIDTH-1:0]       value_i,
  input  wire logic                                last_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [sasum_pkg::TOTAL_W-1:0]     total_o,
  output logic                                     overflow_o
);

  import sasum_pkg::*;

  localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
  localparam int unsigned POS_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned ENTRY_W = ADDR_W + VALUE_WIDTH + TOTAL_W;
  localparam int unsigned PROD_W  = POS_W + 1 + VALUE_WIDTH;
  localparam int unsigned WIDE_W  = (PROD_W > TOTAL_W) ? PROD_W : TOTAL_W;

  sasum_state_e state_q, state_d;

  logic [POS_W-1:0]   depth_q, depth_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;

  // Datapath registers
  logic signed [VALUE_WIDTH-1:0] v_q, v_d;
  logic                          last_q, last_d;
  logic [ADDR_W-1:0]             top_idx_q, top_idx_d;
  logic signed [VALUE_WIDTH-1:0] top_val_q, top_val_d;
  logic [TOTAL_W-1:0]            top_sum_q, top_sum_d;
  logic [TOTAL_W-1:0]            prod_q, prod_d;
  logic [TOTAL_W-1:0]            out_total_q, out_total_d;
  logic                          out_ovf_q, out_ovf_d;

  // Stack RAM port
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // Shared multiplier and adder
  logic [POS_W-1:0]          mul_a;
  logic signed [PROD_W-1:0]  mul_p;
  logic [TOTAL_W-1:0]        ending;
  logic                      stack_nonempty;

  assign stack_nonempty = (depth_q != '0);
  assign mul_a = stack_nonempty ? (pos_q - POS_W'(top_idx_q)) : (pos_q + 1'b1);
  assign mul_p = PROD_W'($signed({1'b0, mul_a})) * PROD_W'(v_q);
  assign ending = (stack_nonempty ? top_sum_q : '0) + prod_q;

  sasum_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LEN)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= '0;
      pos_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      pos_q       <= pos_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    last_q      <= last_d;
    top_idx_q   <= top_idx_d;
    top_val_q   <= top_val_d;
    top_sum_q   <= top_sum_d;
    prod_q      <= prod_d;
    out_total_q <= out_total_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    pos_d       = pos_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    v_d         = v_q;
    last_d      = last_q;
    top_idx_d   = top_idx_q;
    top_val_d   = top_val_q;
    top_sum_d   = top_sum_q;
    prod_d      = prod_q;
    out_total_d = out_total_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = depth_q[ADDR_W-1:0];
    ram_wdata   = {pos_q[ADDR_W-1:0], v_q, ending};
    ram_re      = 1'b0;
    ram_raddr   = ADDR_W'(depth_q - POS_W'(2));
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          v_d    = value_i;
          last_d = last_i;
          if (pos_q == POS_W'(MAX_LEN)) begin
            // sequence too long: drop the element
            ovf_d   = 1'b1;
            state_d = last_i ? ST_FIN : ST_IDLE;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (stack_nonempty && (top_val_q <= v_q)) begin
          depth_d = depth_q - 1'b1;
          if (depth_q > POS_W'(1)) begin
            ram_re  = 1'b1;
            state_d = ST_WAIT;
          end else begin
            state_d = ST_CMP;
          end
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_WAIT: begin
        // refill the top copy from the entry below
        {top_idx_d, top_val_d, top_sum_d} = ram_rdata;
        state_d = ST_CMP;
      end
      ST_MUL: begin
        prod_d  = TOTAL_W'(WIDE_W'(mul_p));
        state_d = ST_ADD;
      end
      ST_ADD: begin
        total_d   = total_q + ending;
        ram_we    = 1'b1;
        top_idx_d = pos_q[ADDR_W-1:0];
        top_val_d = v_q;
        top_sum_d = ending;
        depth_d   = depth_q + 1'b1;
        pos_d     = pos_q + 1'b1;
        state_d   = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_total_d = total_q;
          out_ovf_d   = ovf_q;
          depth_d     = '0;
          pos_d       = '0;
          total_d     = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign total_o     = out_total_q;
  assign overflow_o  = out_ovf_q;

  // Stack never holds more entries than elements seen
  a_depth_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= pos_q)
    else $error("stack depth exceeds element count");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_LEN))
    else $error("position beyond maximum length");

  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |=> (depth_q == $past(depth_q) + 1'b1))
    else $error("push did not grow the stack");

  a_clear_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (pos_q == '0) && (depth_q == '0) && !ovf_q)
    else $error("state not cleared when result issued");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Testbench for subarray_maximum_sum_top: streamed sequences checked against a stack predictor.
module tb_top;
  import sasum_pkg::*;

  localparam int unsigned SEQ_MAX         = MAX_LEN_DEF;
  localparam int unsigned VW              = VALUE_WIDTH_DEF;
  localparam int unsigned IDX_W           = $clog2(SEQ_MAX);
  localparam int unsigned ES_W            = IDX_W + VW;   // sum of maxima ending at one index
  localparam int unsigned ITEMS_PER_PHASE = 260;
  localparam int unsigned STALL_LIMIT     = 40000;        // long enough for a pop run through a full stack
  localparam int unsigned TAIL_CYCLES     = 60;

  // Directed sequences, laid end to end; DIR_LEN gives each sequence's length
  localparam int DIR_N   = 22;
  localparam int DIR_SEQ = 9;
  localparam int DIR_VAL [DIR_N] = '{32767, -32768, 0, -1,
                                     1, 2, 3,              // rising: every value pops all
                                     3, 2, 1,              // falling: stack only grows
                                     5, 5, 5,              // ties pop too
                                     -32768, 32767, -32768, 32767,
                                     7, -3, 7, 0, -3};
  localparam int DIR_LEN [DIR_SEQ] = '{1, 1, 1, 1, 3, 3, 3, 4, 5};

  typedef logic signed [VW-1:0] elem_t;

  typedef struct packed {
    elem_t value;
    logic  last;
  } request_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total;
    logic                      overflow;
  } sum_result_t;

  logic                      clk_i;
  logic                      rst_ni    = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  elem_t                     value     = '0;
  logic                      last      = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [TOTAL_W-1:0] total;
  logic                      overflow;

  subarray_maximum_sum_top #(
    .MAX_LEN    (SEQ_MAX),
    .VALUE_WIDTH(VW)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .value_i    (value),
    .last_i     (last),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .total_o    (total),
    .overflow_o (overflow)
  );

  // Predictor state: monotonic stack plus the running sequence sums
  logic [IDX_W-1:0]          stk_idx [SEQ_MAX];
  elem_t                     stk_val [SEQ_MAX];
  logic signed [ES_W-1:0]    stk_sum [SEQ_MAX];
  logic [IDX_W:0]            stk_depth;
  logic [IDX_W:0]            seq_pos;
  logic signed [TOTAL_W-1:0] seq_total;
  logic                      seq_overflowed;

  request_t    pending_q [$];
  sum_result_t sum_expect_q [$];
  int unsigned queued_cnt    = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned stall_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  request_t    next_req;
  sum_result_t want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_sequence();
    stk_depth      = '0;
    seq_pos        = '0;
    seq_total      = '0;
    seq_overflowed = 1'b0;
  endfunction

  // Fold one accepted request into the stack; a last request yields the expected result.
  function automatic void predict_request(request_t req);
    longint ending;
    if (seq_pos < SEQ_MAX) begin
      while (stk_depth > 0 && stk_val[stk_depth-1] <= req.value)
        stk_depth--;
      if (stk_depth > 0)
        ending = longint'(stk_sum[stk_depth-1]) +
                 longint'(int'(seq_pos) - int'(stk_idx[stk_depth-1])) * longint'(req.value);
      else
        ending = longint'(int'(seq_pos) + 1) * longint'(req.value);
      seq_total              = seq_total + TOTAL_W'(ending);
      stk_idx[stk_depth]     = seq_pos[IDX_W-1:0];
      stk_val[stk_depth]     = req.value;
      stk_sum[stk_depth]     = ES_W'(ending);
      stk_depth++;
      seq_pos++;
    end else begin
      // past the length limit: dropped, only flagged
      seq_overflowed = 1'b1;
    end
    if (req.last) begin
      sum_expect_q.push_back('{total: seq_total, overflow: seq_overflowed});
      clear_sequence();
    end
  endfunction

  task automatic queue_request(elem_t v, logic lst);
    pending_q.push_back('{value: v, last: lst});
    queued_cnt++;
  endtask

  function automatic elem_t random_element();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50)
      return elem_t'($urandom);
    else if (r < 85)
      return elem_t'(int'($urandom_range(8)) - 4);   // narrow range, many ties
    else begin
      case ($urandom_range(3))
        0:       return elem_t'(32767);
        1:       return elem_t'(-32768);
        2:       return elem_t'(0);
        default: return elem_t'(-1);
      endcase
    end
  endfunction

  // One well-formed sequence: ramps (step 0 gives runs of ties) or random content.
  task automatic queue_sequence(int unsigned len);
    int unsigned shape;
    int          base;
    int          step;
    int          v;
    shape = $urandom_range(9);
    base  = int'($urandom_range(65535)) - 32768;
    step  = $urandom_range(3);
    for (int unsigned k = 0; k < len; k++) begin
      if (shape < 4) begin
        v = (shape < 2) ? base + int'(k) * step : base - int'(k) * step;
        if (v > 32767)  v = 32767;
        if (v < -32768) v = -32768;
        queue_request(elem_t'(v), k == len - 1);
      end else begin
        queue_request(random_element(), k == len - 1);
      end
    end
  endtask

  // Sender pauses here until everything queued is taken and every result is back.
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || sum_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: presents the next pending request, holding it until accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request('{value: value, last: last});
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_q.pop_front();
          in_valid <= 1'b1;
          value    <= next_req.value;
          last     <= next_req.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and in-order comparison of results.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (sum_expect_q.size() == 0) begin
          $display("%0t: unexpected result total=%0d overflow=%0b", $time, total, overflow);
          mismatch_cnt++;
        end else begin
          want = sum_expect_q.pop_front();
          if (total !== want.total) begin
            $display("%0t: total mismatch: expected %0d, actual %0d",
                     $time, want.total, total);
            mismatch_cnt++;
          end
          if (overflow !== want.overflow) begin
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, want.overflow, overflow);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: too long without a transfer on either channel ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int          idx;
    int unsigned phase_items;
    int unsigned len;
    int unsigned r;
    clear_sequence();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct <= 22; recv_idle_pct <= 71; end
        1:       begin send_idle_pct <= 71; recv_idle_pct <= 22; end
        default: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
      endcase

      if (phase == 0) begin
        idx = 0;
        for (int s = 0; s < DIR_SEQ; s++)
          for (int k = 0; k < DIR_LEN[s]; k++) begin
            queue_request(elem_t'(DIR_VAL[idx]), k == DIR_LEN[s] - 1);
            idx++;
          end
        wait_drained();
      end

      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 75)      len = $urandom_range(10, 1);
        else if (r < 95) len = $urandom_range(40, 11);
        else             len = $urandom_range(150, 41);
        queue_sequence(len);
        phase_items += len;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
sv/sasum_pkg.sv
sv/sasum_ram.sv
sv/subarray_maximum_sum_top.sv
tb/tb_top.sv
